>>> rtl/ssr_pkg.sv
// Shared types, constants and helpers for the substring replace stream unit.
package ssr_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int MAX_BEATS = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEN     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_PATTERN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_TEXT   = 4'd3;

    typedef struct packed {
        logic [3:0]  slen;
        logic [3:0]  rlen;
        logic [63:0] pattern;
        logic [63:0] rtext;
    } cfg_t;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  k;
        logic [2:0]  last_idx;
        logic        rep;
        logic        last;
        logic        marker;
    } cmd_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                r[i*8 +: 8] = 8'hFF;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/substring_replace_stream_unit.sv
// Top level of the streaming search-and-replace unit: config registers and wiring.
//
// Bytes enter through a queue-style port, one per cycle while the two-entry
// command queue between the matching front end and the output back end has room.
// The front end settles each byte in the same cycle it is accepted; the back
// end then sends the byte's results one beat per cycle while pop is held. A byte
// yields up to eight beats; the front end can take new bytes while the back end
// is still sending earlier results. There is no clearing pass after reset.
module substring_replace_stream_unit #(
    parameter int MAX_SEARCH_LEN  = 8,
    parameter int MAX_REPLACE_LEN = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          out_has_byte,
    output logic                          out_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import ssr_pkg::*;

    localparam int SLEN_LIM = (MAX_SEARCH_LEN < WIN_DEPTH) ? MAX_SEARCH_LEN : WIN_DEPTH;
    localparam int RLEN_LIM = (MAX_REPLACE_LEN < MAX_BEATS) ? MAX_REPLACE_LEN : MAX_BEATS;

    logic [3:0]  search_len_reg;
    logic [63:0] search_pattern_reg;
    logic [3:0]  replace_len_reg;
    logic [63:0] replace_text_reg;
    cfg_t        cfg;
    cmd_t        cmd;
    cmd_t        head;
    logic        cmd_push;
    logic        accept;
    logic        has_data;
    logic        take;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_comb
    begin
        if (search_len_reg == 4'd0) begin
            cfg.slen = 4'd1;
        end else if (search_len_reg > 4'(SLEN_LIM)) begin
            cfg.slen = 4'(SLEN_LIM);
        end else begin
            cfg.slen = search_len_reg;
        end
        cfg.rlen    = (replace_len_reg > 4'(RLEN_LIM)) ? 4'(RLEN_LIM) : replace_len_reg;
        cfg.pattern = search_pattern_reg;
        cfg.rtext   = replace_text_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            search_len_reg     <= 4'd1;
            search_pattern_reg <= '0;
            replace_len_reg    <= 4'd0;
            replace_text_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SEARCH_LEN:     search_len_reg     <= cfg_data[3:0];
                REG_SEARCH_PATTERN: search_pattern_reg <= cfg_data;
                REG_REPLACE_LEN:    replace_len_reg    <= cfg_data[3:0];
                REG_REPLACE_TEXT:   replace_text_reg   <= cfg_data;
                default:            search_len_reg     <= search_len_reg;
            endcase
        end
    end

    ssr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .accept   (accept),
        .cfg      (cfg),
        .cmd      (cmd),
        .cmd_push (cmd_push)
    );

    ssr_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (cmd_push),
        .wr_data  (cmd),
        .rd       (take),
        .head     (head),
        .has_data (has_data),
        .full     (full)
    );

    ssr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rtext        (cfg.rtext),
        .head         (head),
        .has_data     (has_data),
        .take         (take),
        .out_byte     (out_byte),
        .out_has_byte (out_has_byte),
        .out_last     (out_last),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

>>> rtl/ssr_front.sv
// Front end: match window, prefix search and command build for each input byte.
module ssr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic          accept,
    input  ssr_pkg::cfg_t cfg,
    output ssr_pkg::cmd_t cmd,
    output logic          cmd_push
);
    import ssr_pkg::*;

    logic [63:0]        win_reg;
    logic [63:0]        win_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;
    logic [63:0]        wv;
    logic [3:0]         t;
    logic [WIN_DEPTH:0] ok;
    logic [4:0]         lk;
    logic [3:0]         ksel;
    logic [3:0]         m;
    logic               rep;
    logic [4:0]         n_raw;
    logic [3:0]         n;

    always_comb
    begin
        wv = win_reg;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (3'(i) == cnt_reg) begin
                wv[i*8 +: 8] = in_byte;
            end
        end
        t = {1'b0, cnt_reg} + 4'd1;

        // suffix starting at k must be a pattern prefix no longer than slen
        for (int k = 0; k <= WIN_DEPTH; k++) begin
            lk = {1'b0, t} - 5'(k);
            ok[k] = !lk[4] && (lk[3:0] <= cfg.slen) &&
                    ((((wv >> (8 * k)) ^ cfg.pattern) & byte_mask(lk[3:0])) == '0);
        end

        ksel = 4'(WIN_DEPTH);
        for (int k = WIN_DEPTH; k >= 0; k--) begin
            if (ok[k]) begin
                ksel = 4'(k);
            end
        end

        m     = t - ksel;
        rep   = (m == cfg.slen);
        n_raw = {1'b0, ksel} + (rep ? {1'b0, cfg.rlen} : (in_last ? {1'b0, m} : 5'd0));
        n     = (n_raw > 5'(MAX_BEATS)) ? 4'(MAX_BEATS) : n_raw[3:0];

        cmd.bytes    = wv;
        cmd.k        = ksel;
        cmd.rep      = rep;
        cmd.last     = in_last;
        cmd.marker   = (n == 4'd0);
        cmd.last_idx = (n == 4'd0) ? 3'd0 : 3'(n - 4'd1);
        cmd_push     = accept && ((n != 4'd0) || in_last);

        win_next = win_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            win_next = wv >> {ksel, 3'b000};
            cnt_next = (rep || in_last) ? 3'd0 : m[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

>>> rtl/ssr_cmd_queue.sv
// Two-entry command queue between front and back end.
module ssr_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  ssr_pkg::cmd_t wr_data,
    input  logic          rd,
    output ssr_pkg::cmd_t head,
    output logic          has_data,
    output logic          full
);
    import ssr_pkg::*;

    cmd_t       entry0_reg;
    cmd_t       entry0_next;
    cmd_t       entry1_reg;
    cmd_t       entry1_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign head     = entry0_reg;
    assign has_data = (cnt_reg != 2'd0);
    assign full     = (cnt_reg == 2'd2);

    always_comb
    begin
        entry0_next = entry0_reg;
        entry1_next = entry1_reg;
        cnt_next    = cnt_reg;
        case ({wr, rd && has_data})
            2'b11:
            begin
                if (cnt_reg == 2'd1) begin
                    entry0_next = wr_data;
                end else begin
                    entry0_next = entry1_reg;
                    entry1_next = wr_data;
                end
            end
            2'b01:
            begin
                entry0_next = entry1_reg;
                cnt_next    = cnt_reg - 2'd1;
            end
            2'b10:
            begin
                if (cnt_reg == 2'd0) begin
                    entry0_next = wr_data;
                end else begin
                    entry1_next = wr_data;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

endmodule

>>> rtl/ssr_back.sv
// Back end: expands one command into result beats, one beat per cycle while pop is held.
module ssr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [63:0]   rtext,
    input  ssr_pkg::cmd_t head,
    input  logic          has_data,
    output logic          take,
    output logic [7:0]    out_byte,
    output logic          out_has_byte,
    output logic          out_last,
    output logic          empty,
    input  logic          pop
);
    import ssr_pkg::*;

    cmd_t       cur_reg;
    cmd_t       cur_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       busy_reg;
    logic       busy_next;
    logic       done;
    logic [3:0] d;
    logic [7:0] sel;

    always_comb
    begin
        done = (idx_reg == cur_reg.last_idx);
        d    = {1'b0, idx_reg} - cur_reg.k;
        if (({1'b0, idx_reg} < cur_reg.k) || !cur_reg.rep) begin
            sel = cur_reg.bytes[{idx_reg, 3'b000} +: 8];
        end else begin
            sel = rtext[{d[2:0], 3'b000} +: 8];
        end

        empty        = !busy_reg;
        out_has_byte = !cur_reg.marker;
        out_byte     = cur_reg.marker ? 8'h00 : sel;
        out_last     = cur_reg.last && done;

        take      = has_data && (!busy_reg || (pop && done));
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (take) begin
            cur_next  = head;
            idx_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg && pop) begin
            if (done) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

>>> tb/sv/substring_replace_stream_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming search-and-replace unit.
module substring_replace_stream_unit_tb;
    import ssr_pkg::*;

    localparam int SEARCH_MAX  = 8;
    localparam int REPLACE_MAX = 8;
    localparam int SETTLE_CYC  = 24;
    localparam int HOLD_CYC    = 300;
    localparam int PHASE_ITEMS = 24;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } text_beat_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        cfg_index_t  reg_idx;
        logic [63:0] reg_data;
        logic [7:0]  b;
        logic        last;
        logic        fixed;
        text_beat_t  fixed_beat;
    } dir_row_t;

    typedef struct packed {
        logic       fixed;
        text_beat_t beat;
    } item_note_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        out_has_byte;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = REG_SEARCH_LEN;
    logic [63:0] cfg_data = 64'h0;

    // predictor copy of the settings and the partial-match window
    logic [3:0]  set_slen = 4'd1;
    logic [63:0] set_pattern = 64'h0;
    logic [3:0]  set_rlen = 4'd0;
    logic [63:0] set_rtext = 64'h0;
    logic [7:0]  match_buf [WIN_DEPTH];
    int          match_cnt = 0;
    text_beat_t  step_out [MAX_BEATS];
    int          step_cnt;

    text_beat_t  pending_beats [$];
    item_note_t  item_notes [$];
    text_beat_t  want;
    item_note_t  note;
    dir_row_t    dir_rows [$];

    int          err_cnt = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          rand_items = 0;
    logic        hold_on = 1'b0;
    event        hold_ev;

    substring_replace_stream_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .out_has_byte (out_has_byte),
        .out_last     (out_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int eff_slen();
        int n;
        n = set_slen;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > SEARCH_MAX)
        begin
            n = SEARCH_MAX;
        end
        return n;
    endfunction

    function automatic void emit_byte(input logic [7:0] v);
        if (step_cnt < MAX_BEATS)
        begin
            step_out[step_cnt] = '{v, 1'b1, 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void drop_oldest();
        emit_byte(match_buf[0]);
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            match_buf[i] = match_buf[i + 1];
        end
    endfunction

    function automatic logic window_is_prefix(input int slen);
        if (match_cnt > slen)
        begin
            return 1'b0;
        end
        for (int i = 0; i < match_cnt; i++)
        begin
            if (match_buf[i] != set_pattern[i*8 +: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // results of one accepted byte, left in step_out[0 .. step_cnt-1]
    function automatic void rewrite_byte(input logic [7:0] b, input logic last);
        int slen;
        int rlen;
        slen = eff_slen();
        rlen = set_rlen;
        if (rlen > REPLACE_MAX)
        begin
            rlen = REPLACE_MAX;
        end
        step_cnt = 0;
        if (match_cnt >= WIN_DEPTH)
        begin
            drop_oldest();
            match_cnt = WIN_DEPTH - 1;
        end
        match_buf[match_cnt] = b;
        match_cnt++;
        while (match_cnt > 0 && !window_is_prefix(slen))
        begin
            drop_oldest();
            match_cnt--;
        end
        if (match_cnt == slen)
        begin
            for (int i = 0; i < rlen; i++)
            begin
                emit_byte(set_rtext[i*8 +: 8]);
            end
            match_cnt = 0;
        end
        if (last)
        begin
            for (int i = 0; i < match_cnt; i++)
            begin
                emit_byte(match_buf[i]);
            end
            match_cnt = 0;
            if (step_cnt == 0)
            begin
                step_out[0] = '{8'h00, 1'b0, 1'b1};
                step_cnt = 1;
            end
            else
            begin
                step_out[step_cnt - 1].last = 1'b1;
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!empty && pop)
            begin
                if (pending_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat: byte %h has_byte %b last %b",
                             $time, out_byte, out_has_byte, out_last);
                    err_cnt++;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (want.data !== out_byte || want.has_byte !== out_has_byte ||
                        want.last !== out_last)
                    begin
                        $display("%0t: mismatch: expected byte %h has_byte %b last %b, actual byte %h has_byte %b last %b",
                                 $time, want.data, want.has_byte, want.last,
                                 out_byte, out_has_byte, out_last);
                        err_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEARCH_LEN:     set_slen = cfg_data[3:0];
                    REG_SEARCH_PATTERN: set_pattern = cfg_data;
                    REG_REPLACE_LEN:    set_rlen = cfg_data[3:0];
                    REG_REPLACE_TEXT:   set_rtext = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                rewrite_byte(in_byte, in_last);
                note = (item_notes.size() != 0) ? item_notes.pop_front() : '0;
                if (note.fixed)
                begin
                    pending_beats.push_back(note.beat);
                end
                else
                begin
                    for (int i = 0; i < step_cnt; i++)
                    begin
                        pending_beats.push_back(step_out[i]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_on)
        begin
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always
    begin
        @(hold_ev);
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_on <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic fixed,
                             input text_beat_t fixed_beat);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_notes.push_back('{fixed, fixed_beat});
        push <= 1'b1;
        in_byte <= b;
        in_last <= last;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pick_settings();
        logic [7:0]  alpha [3];
        logic [63:0] pat;
        logic [63:0] d;
        int          r;
        wait_idle();
        foreach (alpha[i])
        begin
            alpha[i] = 8'($urandom_range(0, 255));
        end
        // a small alphabet gives self-overlapping patterns
        for (int i = 0; i < 8; i++)
        begin
            pat[i*8 +: 8] = alpha[$urandom_range(0, 2)];
        end
        if ($urandom_range(0, 4) == 0)
        begin
            pat = {$urandom, $urandom};
        end
        d = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        d[3:0] = (r == 0) ? 4'd0 : (r == 1) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(1, 8));
        write_reg(REG_SEARCH_LEN, d);
        write_reg(REG_SEARCH_PATTERN, pat);
        d = {$urandom, $urandom};
        d[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        write_reg(REG_REPLACE_LEN, d);
        write_reg(REG_REPLACE_TEXT, {$urandom, $urandom});
        write_reg(cfg_index_t'($urandom_range(int'(REG_REPLACE_TEXT) + 1, 15)),
                  {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // text built mostly from whole and partial copies of the pattern
    task automatic send_text(input logic close);
        logic [7:0] text [$];
        int         slen;
        int         r;
        int         k;
        slen = eff_slen();
        repeat ($urandom_range(1, 6))
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                k = slen;
            end
            else if (r < 6)
            begin
                k = $urandom_range(1, slen);
            end
            else
            begin
                k = 0;
            end
            for (int i = 0; i < k; i++)
            begin
                text.push_back(set_pattern[i*8 +: 8]);
            end
            if (r >= 6 && r < 9)
            begin
                text.push_back(set_pattern[$urandom_range(0, slen - 1)*8 +: 8]);
            end
            else if (r == 9)
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (text[i])
        begin
            send_byte(text[i], close && (i == text.size() - 1), 1'b0, '0);
            rand_items++;
        end
    endtask

    function automatic dir_row_t item_row(input logic [7:0] b, input logic last);
        return '{ROW_ITEM, REG_SEARCH_LEN, 64'h0, b, last, 1'b0, '0};
    endfunction

    function automatic dir_row_t fixed_row(input logic [7:0] b, input logic last,
                                           input text_beat_t e);
        dir_row_t row;
        row = item_row(b, last);
        row.fixed = 1'b1;
        row.fixed_beat = e;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input cfg_index_t idx, input logic [63:0] d);
        return '{ROW_REG, idx, d, 8'h00, 1'b0, 1'b0, '0};
    endfunction

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic in_reg;
        in_reg = 1'b0;
        dir_rows = '{
            // reset settings: a single zero byte is deleted
            fixed_row(8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1}),
            fixed_row(8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}),
            item_row(8'h80, 1'b0),
            item_row(8'h00, 1'b1),
            // longest pattern and replacement
            reg_row(REG_SEARCH_LEN, 64'd8),
            reg_row(REG_SEARCH_PATTERN, 64'h4847_4645_4443_4241),
            reg_row(REG_REPLACE_LEN, 64'd8),
            reg_row(REG_REPLACE_TEXT, 64'hFFFF_FFFF_FFFF_FFFF),
            item_row(8'h41, 1'b0), item_row(8'h42, 1'b0), item_row(8'h43, 1'b0),
            item_row(8'h44, 1'b0), item_row(8'h45, 1'b0), item_row(8'h46, 1'b0),
            item_row(8'h47, 1'b0), item_row(8'h48, 1'b0),
            item_row(8'h41, 1'b0), item_row(8'h42, 1'b0), item_row(8'h58, 1'b1),
            // zero search length acts as one, oversized replace length saturates
            reg_row(REG_SEARCH_LEN, 64'hFFFF_FFFF_FFFF_FFF0),
            reg_row(REG_SEARCH_PATTERN, 64'h41),
            reg_row(REG_REPLACE_LEN, 64'hF),
            reg_row(REG_REPLACE_TEXT, 64'h0807_0605_0403_0201),
            item_row(8'h41, 1'b1),
            // oversized search length, then a pattern change mid-text
            reg_row(REG_SEARCH_LEN, 64'hF),
            reg_row(REG_SEARCH_PATTERN, 64'h4141_4141_4141_4141),
            reg_row(REG_REPLACE_LEN, 64'h0),
            item_row(8'h41, 1'b0), item_row(8'h41, 1'b0), item_row(8'h41, 1'b0),
            reg_row(REG_SEARCH_LEN, 64'd2),
            reg_row(REG_SEARCH_PATTERN, 64'h4241),
            item_row(8'h42, 1'b1),
            item_row(8'h41, 1'b0), item_row(8'h42, 1'b1),
            item_row(8'h41, 1'b0), item_row(8'h41, 1'b0), item_row(8'h42, 1'b0),
            item_row(8'h00, 1'b1)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_REG)
            begin
                if (!in_reg)
                begin
                    wait_idle();
                    in_reg = 1'b1;
                end
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
            end
            else
            begin
                if (in_reg)
                begin
                    cfg_valid <= 1'b0;
                    in_reg = 1'b0;
                end
                send_byte(dir_rows[r].b, dir_rows[r].last, dir_rows[r].fixed,
                          dir_rows[r].fixed_beat);
            end
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            pick_settings();
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 56; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 56; end
                default: begin send_gap_pct = 26; stall_pct = 26; end
            endcase
            if (ph == 4)
            begin
                -> hold_ev;
            end
            k_loop: while (rand_items < (ph + 1) * PHASE_ITEMS)
            begin
                // now and then leave a text open across the next settings change
                send_text($urandom_range(0, 9) != 0);
            end
        end
        send_text(1'b1);
        wait_idle();

        if (err_cnt == 0 && pending_beats.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
